@@ rtl/ffba_pkg.sv @@
// Shared types and constants of the first-fit block allocator.
`default_nettype none
package ffba_pkg;

   localparam int unsigned PAGE_BYTES          = 4096;
   localparam int unsigned HEADER_BYTES        = 16;
   localparam int unsigned GLOBAL_HEADER_BYTES = 16;
   localparam int unsigned REGION_MAX_BYTES    = 1048576;
   localparam int unsigned MAX_BLOCKS_DEF      = 64;
   localparam int unsigned REGION_RESET        = 4096;

   localparam int unsigned SIZE_W = 21;
   localparam int unsigned OFF_W  = 20;

   typedef enum logic [1:0] {
      MODE_INIT  = 2'd0,
      MODE_ALLOC = 2'd1,
      MODE_FREE  = 2'd2,
      MODE_BAD   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_READ,
      ST_CHECK,
      ST_GRANT,
      ST_SPLIT,
      ST_FREE_WR
   } state_type;

   typedef struct packed {
      logic init_wr;
      logic walk_start;
      logic rd;
      logic advance;
      logic grant_wr;
      logic split_wr;
      logic free_wr;
      logic finish;
      logic fail;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     ready;
      logic     init_ok;
      logic     size_zero;
      logic     hit;
      logic     last;
      logic     split;
   } stat_type;

endpackage
`default_nettype wire

@@ rtl/first_fit_block_allocator.sv @@
// Top level of the first-fit block allocator: controller plus datapath.
//
// Channel   Direction  Handshake               Payload
// req_      in         start & !busy accepts   req_mode, req_alloc_size, req_free_offset
// rsp_      out        rsp_valid, one cycle    rsp_status, rsp_offset
// csr_      in         csr_we writes           csr_wdata (region_bytes)
//
// An item that is decided at once (init, bad mode, early failure) finishes in
// the dispatch state; otherwise the walk visits each table entry in a read
// state and a check state, and a hit adds the table write of a grant or free,
// plus a split write when a grant splits its block. Each entry needs both
// states because its next index comes from the registered read of the table.
// The result strobe comes in the cycle after the last working cycle, when busy is
// already low, so the next item may be accepted in that same cycle.
// Reset is synchronous and active high; it clears the controller, the ready flag,
// the block count and the region register (to 4096). The table needs no clearing:
// only entries below the block count are ever read. The receiver cannot stall.
`default_nettype none
module first_fit_block_allocator #(
   parameter int unsigned MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [1:0]                   req_mode,
   input  wire logic [ffba_pkg::SIZE_W-1:0]  req_alloc_size,
   input  wire logic [ffba_pkg::OFF_W-1:0]   req_free_offset,
   output logic                              rsp_valid,
   output logic                              rsp_status,
   output logic [ffba_pkg::OFF_W-1:0]        rsp_offset,
   input  wire logic                         csr_we,
   input  wire logic [ffba_pkg::SIZE_W-1:0]  csr_wdata
);
   import ffba_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic     ld_req;

   // The controller sequences each item; it sees the datapath only through
   // the status struct and drives it only through the command struct and ld_req.
   ffba_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .stat   (stat),
      .busy   (busy),
      .ld_req (ld_req),
      .cmd    (cmd)
   );

   // The datapath holds the block table memory and the result registers.
   ffba_dp #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .ld_req          (ld_req),
      .req_mode        (req_mode),
      .req_alloc_size  (req_alloc_size),
      .req_free_offset (req_free_offset),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_offset      (rsp_offset)
   );

   // A result is only shown once the controller has gone back to idle.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   // No item completes in the cycle right after its acceptance.
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_valid)
      else $error("result too early");

   // A failing item always reports offset zero.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_offset == '0))
      else $error("failure with nonzero offset");

   // A split is always directly preceded by the grant write.
   a_split_after_grant: assert property (@(posedge clock) disable iff (reset)
      cmd.split_wr |-> $past(cmd.grant_wr))
      else $error("split without grant");

endmodule
`default_nettype wire

@@ rtl/ffba_dp.sv @@
// Datapath of the allocator: request registers, block table memory and result registers.
`default_nettype none
module ffba_dp #(
   parameter int unsigned MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          ld_req,
   input  wire logic [1:0]                    req_mode,
   input  wire logic [ffba_pkg::SIZE_W-1:0]   req_alloc_size,
   input  wire logic [ffba_pkg::OFF_W-1:0]    req_free_offset,
   input  wire logic                          csr_we,
   input  wire logic [ffba_pkg::SIZE_W-1:0]   csr_wdata,
   input  wire ffba_pkg::cmd_type             cmd,
   output ffba_pkg::stat_type                 stat,
   output logic                               rsp_valid,
   output logic                               rsp_status,
   output logic [ffba_pkg::OFF_W-1:0]         rsp_offset
);
   import ffba_pkg::*;

   localparam int unsigned IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);

   logic [1:0]        mode_ff;
   logic [SIZE_W-1:0] size_ff;
   logic [OFF_W-1:0]  off_ff;
   logic [SIZE_W-1:0] region_ff;
   logic              ready_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [CNT_W-1:0]  step_ff;

   logic [OFF_W-1:0]  ent_start_ff;
   logic [OFF_W-1:0]  ent_bytes_ff;
   logic              ent_taken_ff;
   logic [IDX_W-1:0]  ent_link_ff;

   logic [OFF_W-1:0]  mem_start [MAX_BLOCKS];
   logic [OFF_W-1:0]  mem_bytes [MAX_BLOCKS];
   logic              mem_taken [MAX_BLOCKS];
   logic [IDX_W-1:0]  mem_link  [MAX_BLOCKS];

   logic              rsp_valid_ff, rsp_status_ff;
   logic [OFF_W-1:0]  rsp_offset_ff;

   logic [SIZE_W-1:0] rounded;
   logic [SIZE_W-1:0] surplus;
   logic [SIZE_W-1:0] hdr_start;
   logic              we;
   logic [IDX_W-1:0]  wa;
   logic [OFF_W-1:0]  wd_start, wd_bytes;
   logic              wd_taken;
   logic [IDX_W-1:0]  wd_link;
   logic [IDX_W-1:0]  count_idx;

   // Round the region size up to whole pages.
   assign rounded   = (region_ff + SIZE_W'(PAGE_BYTES - 1)) & ~SIZE_W'(PAGE_BYTES - 1);
   assign surplus   = {1'b0, ent_bytes_ff} - size_ff;
   assign hdr_start = {1'b0, ent_start_ff} + SIZE_W'(HEADER_BYTES);
   assign count_idx = count_ff[IDX_W-1:0];

   always_comb begin
      stat.mode      = mode_type'(mode_ff);
      stat.ready     = ready_ff;
      stat.init_ok   = !ready_ff && (region_ff != '0)
                       && (region_ff <= SIZE_W'(REGION_MAX_BYTES))
                       && (rounded > SIZE_W'(GLOBAL_HEADER_BYTES + HEADER_BYTES));
      stat.size_zero = (size_ff == '0);
      if (mode_ff == MODE_ALLOC) begin
         stat.hit = !ent_taken_ff && ({1'b0, ent_bytes_ff} >= size_ff);
      end else begin
         stat.hit = ent_taken_ff && (hdr_start == {1'b0, off_ff});
      end
      stat.last  = ((step_ff + CNT_W'(1)) == count_ff);
      stat.split = (surplus > SIZE_W'(HEADER_BYTES)) && (count_ff < CNT_W'(MAX_BLOCKS));
   end

   // Table write port: one entry per cycle.
   always_comb begin
      we       = 1'b0;
      wa       = idx_ff;
      wd_start = ent_start_ff;
      wd_bytes = ent_bytes_ff;
      wd_taken = ent_taken_ff;
      wd_link  = ent_link_ff;
      if (cmd.init_wr) begin
         we       = 1'b1;
         wa       = '0;
         wd_start = OFF_W'(GLOBAL_HEADER_BYTES);
         wd_bytes = OFF_W'(rounded - SIZE_W'(GLOBAL_HEADER_BYTES + HEADER_BYTES));
         wd_taken = 1'b0;
         wd_link  = '0;
      end else if (cmd.grant_wr) begin
         we       = 1'b1;
         wd_bytes = size_ff[OFF_W-1:0];
         wd_taken = 1'b1;
         if (stat.split) begin
            wd_link = count_idx;
         end
      end else if (cmd.split_wr) begin
         we       = 1'b1;
         wa       = count_idx;
         wd_start = OFF_W'(hdr_start + size_ff);
         wd_bytes = OFF_W'(surplus - SIZE_W'(HEADER_BYTES));
         wd_taken = 1'b0;
      end else if (cmd.free_wr) begin
         we       = 1'b1;
         wd_taken = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem_start[wa] <= wd_start;
         mem_bytes[wa] <= wd_bytes;
         mem_taken[wa] <= wd_taken;
         mem_link[wa]  <= wd_link;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         ent_start_ff <= mem_start[idx_ff];
         ent_bytes_ff <= mem_bytes[idx_ff];
         ent_taken_ff <= mem_taken[idx_ff];
         ent_link_ff  <= mem_link[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (ld_req) begin
         mode_ff <= req_mode;
         size_ff <= req_alloc_size;
         off_ff  <= req_free_offset;
      end
      if (cmd.walk_start) begin
         idx_ff  <= '0;
         step_ff <= '0;
      end else if (cmd.advance) begin
         idx_ff  <= ent_link_ff;
         step_ff <= step_ff + CNT_W'(1);
      end
      rsp_status_ff <= cmd.fail;
      if (!cmd.fail && mode_ff == MODE_ALLOC) begin
         rsp_offset_ff <= hdr_start[OFF_W-1:0];
      end else begin
         rsp_offset_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region_ff    <= SIZE_W'(REGION_RESET);
         ready_ff     <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            region_ff <= csr_wdata;
         end
         if (cmd.init_wr) begin
            ready_ff <= 1'b1;
            count_ff <= CNT_W'(1);
         end else if (cmd.split_wr) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         rsp_valid_ff <= cmd.finish;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_offset = rsp_offset_ff;

endmodule
`default_nettype wire

@@ rtl/ffba_ctrl.sv @@
// Controller state machine of the allocator.
`default_nettype none
module ffba_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire ffba_pkg::stat_type stat,
   output logic                    busy,
   output logic                    ld_req,
   output ffba_pkg::cmd_type       cmd
);
   import ffba_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            state_in = ST_IDLE;
            if (stat.mode == MODE_ALLOC && stat.ready && !stat.size_zero) begin
               state_in = ST_READ;
            end
            if (stat.mode == MODE_FREE && stat.ready) begin
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_CHECK;
         ST_CHECK: begin
            if (stat.hit) begin
               state_in = (stat.mode == MODE_ALLOC) ? ST_GRANT : ST_FREE_WR;
            end else if (stat.last) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_GRANT:   state_in = stat.split ? ST_SPLIT : ST_IDLE;
         ST_SPLIT:   state_in = ST_IDLE;
         ST_FREE_WR: state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd    = '0;
      ld_req = 1'b0;
      busy   = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: ld_req = start;
         ST_DISPATCH: begin
            case (stat.mode)
               MODE_INIT: begin
                  cmd.init_wr = stat.init_ok;
                  cmd.finish  = 1'b1;
                  cmd.fail    = !stat.init_ok;
               end
               MODE_ALLOC: begin
                  if (stat.ready && !stat.size_zero) begin
                     cmd.walk_start = 1'b1;
                  end else begin
                     cmd.finish = 1'b1;
                     cmd.fail   = 1'b1;
                  end
               end
               MODE_FREE: begin
                  if (stat.ready) begin
                     cmd.walk_start = 1'b1;
                  end else begin
                     cmd.finish = 1'b1;
                     cmd.fail   = 1'b1;
                  end
               end
               default: begin
                  cmd.finish = 1'b1;
                  cmd.fail   = 1'b1;
               end
            endcase
         end
         ST_READ: cmd.rd = 1'b1;
         ST_CHECK: begin
            if (!stat.hit) begin
               if (stat.last) begin
                  cmd.finish = 1'b1;
                  cmd.fail   = 1'b1;
               end else begin
                  cmd.advance = 1'b1;
               end
            end
         end
         ST_GRANT: begin
            cmd.grant_wr = 1'b1;
            cmd.finish   = !stat.split;
         end
         ST_SPLIT: begin
            cmd.split_wr = 1'b1;
            cmd.finish   = 1'b1;
         end
         ST_FREE_WR: begin
            cmd.free_wr = 1'b1;
            cmd.finish  = 1'b1;
         end
         default: cmd = '0;
      endcase
   end

endmodule
`default_nettype wire

@@ verif/testbench.sv @@
// Self-checking testbench of the first-fit block allocator.
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import ffba_pkg::*;

   localparam int NBLK = MAX_BLOCKS_DEF;
   localparam int WATCHDOG_CYCLES = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_mode = MODE_INIT;
   logic [SIZE_W-1:0] req_alloc_size = '0;
   logic [OFF_W-1:0] req_free_offset = '0;
   logic rsp_valid;
   logic rsp_status;
   logic [OFF_W-1:0] rsp_offset;
   logic csr_we = 1'b0;
   logic [SIZE_W-1:0] csr_wdata = '0;

   first_fit_block_allocator dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_alloc_size(req_alloc_size),
      .req_free_offset(req_free_offset), .rsp_valid(rsp_valid),
      .rsp_status(rsp_status), .rsp_offset(rsp_offset),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   typedef struct packed {
      logic status;
      logic [OFF_W-1:0] offset;
   } grant_type;

   // Shadow copy of the allocator state.
   logic heap_ready;
   logic [SIZE_W-1:0] heap_region;
   logic [19:0] blk_start [NBLK];
   logic [19:0] blk_bytes [NBLK];
   logic blk_taken [NBLK];
   int unsigned blk_link [NBLK];
   int unsigned blk_count;

   grant_type pending_grants[$];
   int unsigned mismatch_count = 0;
   int unsigned row_mismatch_count = 0;
   int unsigned idle_cycles = 0;
   logic [OFF_W-1:0] granted_offsets[$];

   // Computes the response to one item and updates the shadow state.
   function automatic grant_type predict_grant(mode_type md, logic [SIZE_W-1:0] sz,
                                               logic [OFF_W-1:0] off);
      grant_type g;
      int unsigned r, idx, n, surplus;
      g = '{status: 1'b1, offset: '0};
      idx = 0;
      case (md)
         MODE_INIT: begin
            r = 32'(heap_region);
            if (!heap_ready && r != 0 && r <= REGION_MAX_BYTES) begin
               if (r % PAGE_BYTES != 0) r = r - r % PAGE_BYTES + PAGE_BYTES;
               if (r > GLOBAL_HEADER_BYTES + HEADER_BYTES) begin
                  blk_start[0] = OFF_W'(GLOBAL_HEADER_BYTES);
                  blk_bytes[0] = OFF_W'(r - GLOBAL_HEADER_BYTES - HEADER_BYTES);
                  blk_taken[0] = 1'b0;
                  blk_link[0] = 0;
                  blk_count = 1;
                  heap_ready = 1'b1;
                  g.status = 1'b0;
               end
            end
         end
         MODE_ALLOC: begin
            if (heap_ready && sz != '0) begin
               for (int s = 0; s < blk_count; s++) begin
                  if (!blk_taken[idx] && {1'b0, blk_bytes[idx]} >= sz) begin
                     surplus = 32'(blk_bytes[idx]) - 32'(sz);
                     blk_bytes[idx] = sz[OFF_W-1:0];
                     blk_taken[idx] = 1'b1;
                     g = '{status: 1'b0,
                           offset: OFF_W'(32'(blk_start[idx]) + HEADER_BYTES)};
                     if (surplus > HEADER_BYTES && blk_count < NBLK) begin
                        n = blk_count;
                        blk_start[n] = OFF_W'(32'(blk_start[idx]) + HEADER_BYTES
                                              + 32'(sz));
                        blk_bytes[n] = OFF_W'(surplus - HEADER_BYTES);
                        blk_taken[n] = 1'b0;
                        blk_link[n] = blk_link[idx];
                        blk_link[idx] = n;
                        blk_count = n + 1;
                     end
                     break;
                  end
                  idx = blk_link[idx];
               end
            end
         end
         MODE_FREE: begin
            if (heap_ready) begin
               for (int s = 0; s < blk_count; s++) begin
                  if (blk_taken[idx] && 32'(blk_start[idx]) + HEADER_BYTES == 32'(off))
                  begin
                     blk_taken[idx] = 1'b0;
                     g.status = 1'b0;
                     break;
                  end
                  idx = blk_link[idx];
               end
            end
         end
         default: ;
      endcase
      return g;
   endfunction

   // Response checker and watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("testbench: errors");
            $finish;
         end
      end
      if (rsp_valid) begin
         if (pending_grants.size() == 0) begin
            $display("%0t: unexpected response status=%0b offset=%0h", $time,
                     rsp_status, rsp_offset);
            mismatch_count++;
         end else begin
            grant_type exp_g;
            exp_g = pending_grants.pop_front();
            if (rsp_status !== exp_g.status) begin
               $display("%0t: status expected %0b actual %0b", $time, exp_g.status,
                        rsp_status);
               mismatch_count++;
            end
            if (rsp_offset !== exp_g.offset) begin
               $display("%0t: offset expected %0h actual %0h", $time, exp_g.offset,
                        rsp_offset);
               mismatch_count++;
            end
            if (!exp_g.status && rsp_status === 1'b0 && rsp_offset != '0)
               granted_offsets.push_back(rsp_offset);
         end
      end
   end

   // Issues one item and waits until it is accepted. When has_exp is set the
   // typed-in response must also agree with the predictor.
   task automatic send_item(mode_type md, logic [SIZE_W-1:0] sz, logic [OFF_W-1:0] off,
                            logic has_exp = 1'b0, grant_type typed = '0);
      grant_type g;
      start <= 1'b1;
      req_mode <= md;
      req_alloc_size <= sz;
      req_free_offset <= off;
      do @(posedge clock); while (busy);
      g = predict_grant(md, sz, off);
      if (has_exp && g != typed) begin
         $display("%0t: table row expected %0b/%0h, predictor %0b/%0h", $time,
                  typed.status, typed.offset, g.status, g.offset);
         row_mismatch_count++;
      end
      pending_grants.push_back(g);
   endtask

   task automatic pause_sender();
      start <= 1'b0;
      @(posedge clock);
   endtask

   // Lets all outstanding responses drain, then a margin for the table walk.
   task automatic drain_all();
      start <= 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (4 * NBLK + 8) @(posedge clock);
   endtask

   task automatic write_region(logic [SIZE_W-1:0] value);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      heap_region = value;
   endtask

   // The heap is not reset again; reset is asserted once, so re-setup is emulated by
   // freeing nothing and staying in the current region. Instead a new region
   // phase works on the existing heap after a register change (init fails).
   typedef struct {
      mode_type md;
      logic [SIZE_W-1:0] sz;
      logic [OFF_W-1:0] off;
      logic has_exp;
      grant_type typed;
   } row_type;

   row_type directed_rows[$];

   function automatic row_type mk(mode_type md, int sz, int off, int he, int st,
                                  int ofs);
      row_type r;
      r.md = md; r.sz = SIZE_W'(sz); r.off = OFF_W'(off); r.has_exp = (he != 0);
      r.typed = '{status: (st != 0), offset: OFF_W'(ofs)};
      return r;
   endfunction

   initial begin
      int unsigned burst, sent, choice, sz;
      logic [OFF_W-1:0] off;
      heap_ready = 1'b0;
      heap_region = SIZE_W'(REGION_RESET);
      blk_count = 0;
      for (int i = 0; i < NBLK; i++) begin
         blk_start[i] = '0; blk_bytes[i] = '0; blk_taken[i] = 1'b0; blk_link[i] = 0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: before init, bad register values, then a small heap.
      directed_rows.push_back(mk(MODE_ALLOC, 16, 0, 1, 1, 0));
      directed_rows.push_back(mk(MODE_FREE, 0, 32, 1, 1, 0));
      directed_rows.push_back(mk(MODE_BAD, 16, 0, 1, 1, 0));
      foreach (directed_rows[i])
         send_item(directed_rows[i].md, directed_rows[i].sz, directed_rows[i].off,
                   directed_rows[i].has_exp, directed_rows[i].typed);
      directed_rows.delete();
      drain_all();
      write_region('0);
      send_item(MODE_INIT, '0, '0, 1'b1, '{status: 1'b1, offset: '0});
      drain_all();
      write_region(SIZE_W'(REGION_MAX_BYTES + 1));
      send_item(MODE_INIT, '0, '0, 1'b1, '{status: 1'b1, offset: '0});
      drain_all();
      write_region(SIZE_W'(1));
      directed_rows.push_back(mk(MODE_INIT, 0, 0, 1, 0, 0));
      directed_rows.push_back(mk(MODE_INIT, 0, 0, 1, 1, 0));
      directed_rows.push_back(mk(MODE_ALLOC, 0, 0, 1, 1, 0));
      directed_rows.push_back(mk(MODE_ALLOC, 100, 0, 1, 0, 32));
      directed_rows.push_back(mk(MODE_ALLOC, 20, 0, 0, 0, 0));
      directed_rows.push_back(mk(MODE_ALLOC, 1 << 20, 0, 1, 1, 0));
      directed_rows.push_back(mk(MODE_ALLOC, (1 << 21) - 1, 0, 1, 1, 0));
      directed_rows.push_back(mk(MODE_FREE, 0, 32, 1, 0, 0));
      directed_rows.push_back(mk(MODE_FREE, 0, 32, 1, 1, 0));
      directed_rows.push_back(mk(MODE_FREE, 0, (1 << 20) - 1, 1, 1, 0));
      directed_rows.push_back(mk(MODE_ALLOC, 90, 0, 0, 0, 0));
      directed_rows.push_back(mk(MODE_ALLOC, 3900, 0, 0, 0, 0));
      directed_rows.push_back(mk(MODE_ALLOC, 8, 0, 0, 0, 0));
      directed_rows.push_back(mk(MODE_BAD, (1 << 21) - 1, (1 << 20) - 1, 1, 1, 0));
      foreach (directed_rows[i])
         send_item(directed_rows[i].md, directed_rows[i].sz, directed_rows[i].off,
                   directed_rows[i].has_exp, directed_rows[i].typed);
      drain_all();
      write_region(SIZE_W'(REGION_MAX_BYTES));

      // Random part: mostly small allocations and frees of granted offsets so
      // the table fills up; a few large sizes and some noise.
      sent = 0;
      while (sent < 1500) begin
         burst = $urandom_range(1, 12);
         for (int b = 0; b < burst; b++) begin
            choice = $urandom_range(0, 99);
            if (choice < 50) begin
               sz = ($urandom_range(0, 9) == 0) ? $urandom_range(0, (1 << 21) - 1)
                                                : $urandom_range(1, 200);
               send_item(MODE_ALLOC, SIZE_W'(sz), OFF_W'($urandom));
            end else if (choice < 85 && granted_offsets.size() != 0) begin
               off = granted_offsets[$urandom_range(0, granted_offsets.size() - 1)];
               send_item(MODE_FREE, SIZE_W'($urandom), off);
            end else if (choice < 93) begin
               send_item(MODE_FREE, SIZE_W'($urandom), OFF_W'($urandom));
            end else if (choice < 97) begin
               send_item(MODE_INIT, SIZE_W'($urandom), OFF_W'($urandom));
            end else begin
               send_item(MODE_BAD, SIZE_W'($urandom), OFF_W'($urandom));
            end
            sent++;
         end
         if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 20)) pause_sender();
         if (sent % 500 < burst) begin
            drain_all();
            write_region(SIZE_W'($urandom_range(0, (1 << SIZE_W) - 1)));
         end
      end

      drain_all();
      if (mismatch_count == 0 && row_mismatch_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end
endmodule
`default_nettype wire
